[rtl/sawad_pkg.sv]
// Shared constants, types and helpers for the spark angle wrap and arm decision block.
package sawad_pkg;

  localparam int CHANNELS_DEF  = 4;
  localparam int FRAC_BITS_DEF = 8;

  localparam int CH_W     = 2;
  localparam int ANGLE_W  = 24;
  localparam int SPAN_W   = 23;
  localparam int TIMER_W  = 32;
  localparam int DWELL_W  = 16;
  localparam int DIV_W    = 32;
  localparam int ACTION_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int S24_MAX = 8388607;
  localparam int S24_MIN = -8388608;

  localparam logic [CFG_IDX_W-1:0] REG_WRAP_LOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_SPAN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ARM_MARGIN = 2'd2;

  localparam logic signed [ANGLE_W-1:0] WRAP_LOW_RST   = -24'sd23040;
  localparam logic [SPAN_W-1:0]         WRAP_SPAN_RST  = 23'd184320;
  localparam logic signed [ANGLE_W-1:0] ARM_MARGIN_RST = 24'sd15360;

  localparam logic [ACTION_W-1:0] ACT_NONE    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_ARM     = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_REBUILD = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_DISARM  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DIVZERO = 3'd4;

  typedef struct packed {
    logic done;
  } div_stat_t;

  function automatic logic signed [ANGLE_W-1:0] sat24(input logic signed [ANGLE_W+1:0] v);
    logic signed [ANGLE_W-1:0] r;
    if (v > 26'(S24_MAX)) begin
      r = 24'(S24_MAX);
    end else if (v < $signed(26'(S24_MIN))) begin
      r = 24'(S24_MIN);
    end else begin
      r = v[ANGLE_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/sawad_wrap.sv]
// Angle window wrap: +/- one span if outside, then saturate to 24 bits.
module sawad_wrap import sawad_pkg::*; (
  input  logic signed [ANGLE_W:0]   diff_i,
  input  logic signed [ANGLE_W-1:0] wrap_low_i,
  input  logic [SPAN_W-1:0]         wrap_span_i,
  output logic signed [ANGLE_W-1:0] wrapped_o
);

  logic signed [ANGLE_W+1:0] d_ext;
  logic signed [ANGLE_W+1:0] low_ext;
  logic signed [ANGLE_W+1:0] span_ext;
  logic signed [ANGLE_W+1:0] high_ext;
  logic signed [ANGLE_W+1:0] w;

  always_comb begin
    d_ext    = (ANGLE_W+2)'(diff_i);
    low_ext  = (ANGLE_W+2)'(wrap_low_i);
    span_ext = $signed({3'b000, wrap_span_i});
    high_ext = low_ext + span_ext;
    if (d_ext < low_ext) begin
      w = d_ext + span_ext;
    end else if (d_ext < high_ext) begin
      w = d_ext;
    end else begin
      w = d_ext - span_ext;
    end
    wrapped_o = sat24(w);
  end

endmodule

[rtl/sawad_div.sv]
// Restoring signed divider, one quotient bit per cycle, quotient saturated to 24 bits.
module sawad_div import sawad_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int NUM_W = 37 + FRAC_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [NUM_W-1:0]   num_i,
  input  logic signed [DIV_W-1:0]   den_i,
  output div_stat_t                 stat_o,
  output logic signed [ANGLE_W-1:0] quot_o
);

  localparam int MAG_W = NUM_W - 1;
  localparam int CNT_W = $clog2(MAG_W + 1);

  localparam logic [1:0] DV_IDLE = 2'd0;
  localparam logic [1:0] DV_RUN  = 2'd1;
  localparam logic [1:0] DV_FIN  = 2'd2;

  localparam logic [MAG_W-1:0] POS_LIM = MAG_W'(S24_MAX);
  localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(S24_MAX) + MAG_W'(1);

  logic [1:0]       st_q, st_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [MAG_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] den_q, den_d;
  logic             neg_q, neg_d;

  logic [MAG_W-1:0] num_abs;
  logic [DIV_W:0]   rem_sh;
  logic             ge;

  always_comb begin
    num_abs = num_i[NUM_W-1] ? MAG_W'(-num_i) : MAG_W'(num_i);
    rem_sh  = {rem_q, quo_q[MAG_W-1]};
    ge      = rem_sh >= {1'b0, den_q};

    st_d  = st_q;
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    neg_d = neg_q;

    case (st_q)
      DV_IDLE: begin
        if (start_i) begin
          quo_d = num_abs;
          rem_d = '0;
          den_d = den_i[DIV_W-1] ? DIV_W'(-den_i) : DIV_W'(den_i);
          neg_d = num_i[NUM_W-1] ^ den_i[DIV_W-1];
          cnt_d = CNT_W'(MAG_W);
          st_d  = DV_RUN;
        end
      end
      DV_RUN: begin
        rem_d = ge ? DIV_W'(rem_sh - {1'b0, den_q}) : rem_sh[DIV_W-1:0];
        quo_d = {quo_q[MAG_W-2:0], ge};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          st_d = DV_FIN;
        end
      end
      DV_FIN: begin
        st_d = DV_IDLE;
      end
      default: begin
        st_d = DV_IDLE;
      end
    endcase
  end

  always_comb begin
    if (!neg_q) begin
      quot_o = (quo_q > POS_LIM) ? ANGLE_W'(S24_MAX) : $signed(quo_q[ANGLE_W-1:0]);
    end else begin
      quot_o = (quo_q > NEG_LIM) ? ANGLE_W'(S24_MIN) : $signed(-quo_q[ANGLE_W-1:0]);
    end
    stat_o.done = (st_q == DV_FIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= DV_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

endmodule

[rtl/spark_angle_wrap_arm_decision.sv]
// Top level: input capture, decision sequencer, armed flags and result register.
// Usage:
//   Input channel: in_valid_i / in_stall_o with one port per field. A transfer
//   happens on a rising edge with valid high and stall low. in_stall_o is high
//   from a transfer until that item's result is loaded into the output register.
//   Output channel: out_valid_o / out_stall_i; the result register holds its
//   value while out_stall_i is high, and the next item may be taken meanwhile.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 wrap_low, 1 wrap_span, 2 arm_margin); other indexes are dropped.
// Sequence:
//   Items that need a lead count (valid, disarmed channel, nonzero divisor) pass
//   through the wrap, divide and done states before out_valid_o, the
//   restoring divider retiring one quotient bit per cycle; all other items
//   skip the divide state. One item is in work at a time: a new item is taken
//   only after the last result is loaded into the result register, which
//   waits while that register still holds an earlier stalled result.
// Reset: rst_ni clears all armed flags, the sequencer and the output valid,
//   and loads the configuration registers with their reset values.
module spark_angle_wrap_arm_decision import sawad_pkg::*; #(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [CH_W-1:0]           channel_i,
  input  logic signed [ANGLE_W-1:0] spark_angle_i,
  input  logic signed [ANGLE_W-1:0] base_angle_i,
  input  logic [TIMER_W-1:0]        timer_base_i,
  input  logic [DWELL_W-1:0]        dwell_i,
  input  logic signed [DIV_W-1:0]   divisor_i,
  input  logic                      target_zero_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [ANGLE_W-1:0] wrapped_angle_o,
  output logic signed [ANGLE_W-1:0] lead_count_o,
  output logic [ACTION_W-1:0]       action_o
);

  localparam int NUM_W = 37 + FRAC_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WRAP = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                st_q, st_d;
  logic [CHANNELS-1:0]       armed_q, armed_d;
  logic signed [ANGLE_W-1:0] wrap_low_q;
  logic [SPAN_W-1:0]         wrap_span_q;
  logic signed [ANGLE_W-1:0] arm_margin_q;

  logic [CH_W-1:0]           ch_q;
  logic signed [ANGLE_W:0]   diff_q;
  logic [TIMER_W-1:0]        sum_q;
  logic signed [DIV_W-1:0]   div_q;
  logic                      tzero_q;
  logic signed [ANGLE_W-1:0] wrap_q;
  logic signed [ANGLE_W-1:0] lead_q;

  logic                      out_valid_q;
  logic signed [ANGLE_W-1:0] out_wrap_q;
  logic signed [ANGLE_W-1:0] out_lead_q;
  logic [ACTION_W-1:0]       out_act_q;

  logic                      in_xfer;
  logic                      out_free;
  logic                      ch_ok;
  logic                      ch_armed;
  logic                      div_zero;
  logic                      div_start;
  logic signed [NUM_W-1:0]   sum_ext;
  logic signed [NUM_W-1:0]   num;
  logic signed [ANGLE_W-1:0] wrapped;
  logic signed [ANGLE_W-1:0] quot;
  div_stat_t                 div_stat;
  logic signed [ANGLE_W:0]   margin_diff;
  logic                      arm_hit;
  logic [ACTION_W-1:0]       act;

  sawad_wrap u_wrap (
    .diff_i      (diff_q),
    .wrap_low_i  (wrap_low_q),
    .wrap_span_i (wrap_span_q),
    .wrapped_o   (wrapped)
  );

  sawad_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (div_q),
    .stat_o  (div_stat),
    .quot_o  (quot)
  );

  assign in_stall_o = (st_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    ch_ok    = (int'(ch_q) < CHANNELS);
    ch_armed = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (int'(ch_q) == i) begin
        ch_armed = armed_q[i];
      end
    end
    div_zero  = (div_q == '0);
    sum_ext   = NUM_W'($signed(sum_q));
    num       = ((sum_ext <<< 5) - (sum_ext <<< 1)) <<< FRAC_BITS;
    div_start = (st_q == ST_WRAP) && ch_ok && !ch_armed && !div_zero;

    margin_diff = (ANGLE_W+1)'(wrap_q) - (ANGLE_W+1)'(lead_q);
    arm_hit     = margin_diff < (ANGLE_W+1)'(arm_margin_q);

    act = ACT_NONE;
    if (ch_ok) begin
      if (!ch_armed) begin
        if (div_zero) begin
          act = ACT_DIVZERO;
        end else if (arm_hit) begin
          act = ACT_ARM;
        end
      end else if (tzero_q) begin
        act = ACT_DISARM;
      end else begin
        act = ACT_REBUILD;
      end
    end

    armed_d = armed_q;
    st_d    = st_q;
    case (st_q)
      ST_IDLE: begin
        if (in_xfer) begin
          st_d = ST_WRAP;
        end
      end
      ST_WRAP: begin
        st_d = div_start ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          st_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          st_d = ST_IDLE;
          for (int i = 0; i < CHANNELS; i++) begin
            if (int'(ch_q) == i) begin
              if (act == ACT_ARM) begin
                armed_d[i] = 1'b1;
              end else if (act == ACT_DISARM) begin
                armed_d[i] = 1'b0;
              end
            end
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      armed_q      <= '0;
      out_valid_q  <= 1'b0;
      wrap_low_q   <= WRAP_LOW_RST;
      wrap_span_q  <= WRAP_SPAN_RST;
      arm_margin_q <= ARM_MARGIN_RST;
    end else begin
      st_q    <= st_d;
      armed_q <= armed_d;
      if ((st_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WRAP_LOW:   wrap_low_q   <= $signed(cfg_data_i);
          REG_WRAP_SPAN:  wrap_span_q  <= cfg_data_i[SPAN_W-1:0];
          REG_ARM_MARGIN: arm_margin_q <= $signed(cfg_data_i);
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ch_q    <= channel_i;
      diff_q  <= (ANGLE_W+1)'(spark_angle_i) - (ANGLE_W+1)'(base_angle_i);
      sum_q   <= timer_base_i + {12'd0, dwell_i, 4'd0};
      div_q   <= divisor_i;
      tzero_q <= target_zero_i;
      lead_q  <= '0;
    end
    if (st_q == ST_WRAP) begin
      wrap_q <= wrapped;
    end
    if ((st_q == ST_DIV) && div_stat.done) begin
      lead_q <= quot;
    end
    if ((st_q == ST_DONE) && out_free) begin
      out_wrap_q <= wrap_q;
      out_lead_q <= lead_q;
      out_act_q  <= act;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign wrapped_angle_o = out_wrap_q;
  assign lead_count_o    = out_lead_q;
  assign action_o        = out_act_q;

endmodule
